// File: rtl/lpr_pkg.sv
package lpr_pkg;

  // Request kinds carried on the input tuser bit
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam int unsigned PITCH_W   = 12;
  localparam int unsigned OFFSET_W  = 22;
  localparam int unsigned COLOR_W   = 32;
  localparam logic [PITCH_W-1:0] PITCH_RESET = 12'd800;

  // Per-pixel marks passed from the walker to the output pipeline
  typedef struct packed {
    logic valid;  // a pixel was produced
    logic last;   // final endpoint of the line
  } pix_flags_t;

endpackage

// File: rtl/lpr_walker.sv
module lpr_walker import lpr_pkg::*; #(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  op_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] stop_x_i,
  input  logic [COORD_BITS-1:0] stop_y_i,
  input  logic [COLOR_W-1:0]    color_i,
  output logic [COORD_BITS-1:0] pix_x_o,
  output logic [COORD_BITS-1:0] pix_y_o,
  output logic [COLOR_W-1:0]    pix_color_o,
  output pix_flags_t            pix_flags_o
);

  localparam int unsigned ErrW = COORD_BITS + 3;

  logic [COORD_BITS-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [ErrW-1:0] err_q, err_d, taken_q, taken_d;
  logic [COORD_BITS:0]    kept_q, kept_d;
  logic [COORD_BITS-1:0]  limit_q, limit_d;
  logic                   y_major_q, y_major_d, down_q, down_d, busy_q, busy_d;
  logic [COLOR_W-1:0]     color_q, color_d;

  logic [COORD_BITS-1:0] adx, ady, dmaj, dmin, sx, sy, ex, ey, minor_nxt, major_nxt;
  logic                  ymaj, swap, move;

  // Setup path: spans, major axis, endpoint order
  always_comb begin
    adx  = (stop_x_i > start_x_i) ? stop_x_i - start_x_i : start_x_i - stop_x_i;
    ady  = (stop_y_i > start_y_i) ? stop_y_i - start_y_i : start_y_i - stop_y_i;
    ymaj = adx < ady;
    swap = ymaj ? (start_y_i > stop_y_i) : (start_x_i > stop_x_i);
    sx   = swap ? stop_x_i  : start_x_i;
    sy   = swap ? stop_y_i  : start_y_i;
    ex   = swap ? start_x_i : stop_x_i;
    ey   = swap ? start_y_i : stop_y_i;
    dmaj = ymaj ? ady : adx;
    dmin = ymaj ? adx : ady;
  end

  // Step path: minor moves while the error term is non-negative
  always_comb begin
    move      = !err_q[ErrW-1];
    major_nxt = (y_major_q ? cur_y_q : cur_x_q) + COORD_BITS'(1);
    minor_nxt = y_major_q ? cur_x_q : cur_y_q;
    if (move) begin
      minor_nxt = down_q ? minor_nxt - COORD_BITS'(1) : minor_nxt + COORD_BITS'(1);
    end
  end

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    err_d       = err_q;
    taken_d     = taken_q;
    kept_d      = kept_q;
    limit_d     = limit_q;
    y_major_d   = y_major_q;
    down_d      = down_q;
    busy_d      = busy_q;
    color_d     = color_q;
    pix_x_o     = '0;
    pix_y_o     = '0;
    pix_color_o = '0;
    pix_flags_o = '0;
    if (op_i == OP_START) begin
      y_major_d = ymaj;
      down_d    = ymaj ? !(ex > sx) : !(ey > sy);
      limit_d   = ymaj ? ey : ex;
      err_d     = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
      taken_d   = $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
      kept_d    = {dmin, 1'b0};
      cur_x_d   = sx;
      cur_y_d   = sy;
      color_d   = color_i;
      busy_d    = (dmaj != '0);
      pix_x_o   = sx;
      pix_y_o   = sy;
      pix_color_o       = color_i;
      pix_flags_o.valid = 1'b1;
      pix_flags_o.last  = (dmaj == '0);
    end else if (busy_q) begin
      err_d   = err_q + (move ? taken_q : $signed({2'b00, kept_q}));
      cur_x_d = y_major_q ? minor_nxt : major_nxt;
      cur_y_d = y_major_q ? major_nxt : minor_nxt;
      busy_d  = (major_nxt != limit_q);
      pix_x_o = cur_x_d;
      pix_y_o = cur_y_d;
      pix_color_o       = color_q;
      pix_flags_o.valid = 1'b1;
      pix_flags_o.last  = (major_nxt == limit_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      err_q     <= '0;
      taken_q   <= '0;
      kept_q    <= '0;
      limit_q   <= '0;
      y_major_q <= 1'b0;
      down_q    <= 1'b0;
      busy_q    <= 1'b0;
      color_q   <= '0;
    end else if (accept_i) begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      err_q     <= err_d;
      taken_q   <= taken_d;
      kept_q    <= kept_d;
      limit_q   <= limit_d;
      y_major_q <= y_major_d;
      down_q    <= down_d;
      busy_q    <= busy_d;
      color_q   <= color_d;
    end
  end

endmodule

// File: rtl/line_pixel_rasterizer.sv
// Channel  | Dir | Handshake                  | Payload
// s_axis   | in  | s_axis_tvalid/tready       | tuser: op; tdata: endpoints, color
// m_axis   | out | m_axis_tvalid/tready       | tuser: pixel_valid; tlast: last_pixel;
//          |     |                            | tdata: x, y, offset, color
// cfg      | in  | cfg_valid_i/cfg_ready_o    | cfg_data_i: row_pitch
//
// One request per clock while m_axis does not stall. Each request yields
// one result, held in the middle stage after accept (when the walker state
// updates) and then in the output stage with its offset multiply-add.
// Reset clears the walk (idle), the pipeline valids and sets row_pitch to 800.
// A stalled m_axis holds its result; the middle stage keeps taking requests
// until it is also full, then s_axis_tready drops.
module line_pixel_rasterizer import lpr_pkg::*; #(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: start_x, start_y, stop_x, stop_y, line_color (low bit up), zero pad
  input  logic [((4*COORD_BITS+COLOR_W+7)/8)*8-1:0] s_axis_tdata,
  // tuser: op
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: pixel_x, pixel_y, pixel_offset, color_out (low bit up), zero pad
  output logic [((2*COORD_BITS+OFFSET_W+COLOR_W+7)/8)*8-1:0] m_axis_tdata,
  // tuser: pixel_valid
  output logic                         m_axis_tuser,
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [PITCH_W-1:0]           cfg_data_i
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned InW    = 4 * C + COLOR_W;
  localparam int unsigned InPadW = ((InW + 7) / 8) * 8;
  localparam int unsigned OutW   = 2 * C + OFFSET_W + COLOR_W;
  localparam int unsigned OutPadW = ((OutW + 7) / 8) * 8;

  logic [PITCH_W-1:0] pitch_q;
  logic               accept;

  // walker outputs
  logic [C-1:0]       w_x, w_y;
  logic [COLOR_W-1:0] w_color;
  pix_flags_t         w_flags;

  // middle stage
  logic               s1_v_q;
  logic [C-1:0]       s1_x_q, s1_y_q;
  logic [COLOR_W-1:0] s1_color_q;
  pix_flags_t         s1_flags_q;

  // output stage
  logic                s2_v_q;
  logic [C-1:0]        s2_x_q, s2_y_q;
  logic [OFFSET_W-1:0] s2_off_q, s2_off_d;
  logic [COLOR_W-1:0]  s2_color_q;
  pix_flags_t          s2_flags_q;
  logic [C+PITCH_W-1:0] row_prod;
  logic                s2_ready, s1_ready, s2_load;

  logic [InPadW-1:0] in_word;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= PITCH_RESET;
    end else if (cfg_valid_i) begin
      pitch_q <= cfg_data_i;
    end
  end

  // Stall chain: each stage moves when the one after it frees up
  assign s2_ready      = !s2_v_q || m_axis_tready;
  assign s2_load       = s1_v_q && s2_ready;
  assign s1_ready      = !s1_v_q || s2_ready;
  assign s_axis_tready = s1_ready;
  assign accept        = s_axis_tvalid && s1_ready;

  assign in_word = s_axis_tdata;

  lpr_walker #(.COORD_BITS(C)) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (s_axis_tuser),
    .start_x_i   (in_word[C-1:0]),
    .start_y_i   (in_word[2*C-1:C]),
    .stop_x_i    (in_word[3*C-1:2*C]),
    .stop_y_i    (in_word[4*C-1:3*C]),
    .color_i     (in_word[InW-1:4*C]),
    .pix_x_o     (w_x),
    .pix_y_o     (w_y),
    .pix_color_o (w_color),
    .pix_flags_o (w_flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (s2_ready) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q     <= w_x;
      s1_y_q     <= w_y;
      s1_color_q <= w_color;
      s1_flags_q <= w_flags;
    end
  end

  // Offset = x + y * pitch, wrapped to the offset width
  assign row_prod = {{PITCH_W{1'b0}}, s1_y_q} * {{C{1'b0}}, pitch_q};
  assign s2_off_d = OFFSET_W'(row_prod) + OFFSET_W'(s1_x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_x_q     <= s1_x_q;
      s2_y_q     <= s1_y_q;
      s2_off_q   <= s2_off_d;
      s2_color_q <= s1_color_q;
      s2_flags_q <= s1_flags_q;
    end
  end

  assign m_axis_tvalid = s2_v_q;
  assign m_axis_tuser  = s2_flags_q.valid;
  assign m_axis_tlast  = s2_flags_q.last;
  assign m_axis_tdata  = OutPadW'({s2_color_q, s2_off_q, s2_y_q, s2_x_q});

endmodule

// File: rtl/lpr_checker.sv
module lpr_checker import lpr_pkg::*; #(
  parameter int unsigned COORD_BITS = 11
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [((2*COORD_BITS+OFFSET_W+COLOR_W+7)/8)*8-1:0] m_axis_tdata,
  input logic                         m_axis_tuser,
  input logic                         m_axis_tlast
);

  // held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a step with no line gives an all-zero result
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
    else $error("invalid pixel carries data");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last mark on invalid pixel");

  // input only backs up when the output is blocked
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

endmodule

bind line_pixel_rasterizer lpr_checker #(.COORD_BITS(COORD_BITS)) u_lpr_checker (.*);
